@@ hw/rtl/dfp_pkg.sv @@
// Shared types and constants for the downlink frame parser.
package dfp_pkg;

    localparam int ACC_W          = 17;   // varint accumulator width
    localparam int VCNT_W         = 4;    // varint byte counter width
    localparam int VARINT_MAX     = 10;   // longest legal varint in bytes
    localparam int POS_W          = 8;    // field position, wraps at 256
    localparam int TYPE_W         = 3;
    localparam int VALUE_W        = 8;

    localparam logic [TYPE_W-1:0] TYPE_WELCOME = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_ERROR   = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_MESSAGE = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_MAX     = 3'd4;

    typedef enum logic [6:0] {
        PH_TYPE      = 7'b0000001,
        PH_REASON    = 7'b0000010,
        PH_TOPIC_LEN = 7'b0000100,
        PH_TOPIC     = 7'b0001000,
        PH_DATA_LEN  = 7'b0010000,
        PH_DATA      = 7'b0100000,
        PH_DONE      = 7'b1000000
    } phase_t;

    typedef enum logic [2:0] {
        KIND_TYPE   = 3'd0,
        KIND_REASON = 3'd1,
        KIND_TOPIC  = 3'd2,
        KIND_DATA   = 3'd3,
        KIND_OK     = 3'd4,
        KIND_FAIL   = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   index;
        logic               last;
    } result_t;

    // up to two results caused by one input byte
    typedef struct packed {
        result_t    r1;
        result_t    r0;
        logic [1:0] n;
    } bundle_t;

endpackage

@@ hw/rtl/dfp_parser.sv @@
// Frame parser state and the per-byte next-state / result logic.
module dfp_parser #(
    parameter int TOPIC_CAPACITY = 64,
    parameter int DATA_CAPACITY  = 256,
    parameter int BL_W           = 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [dfp_pkg::VALUE_W-1:0]   data_byte,
    input  logic                          frame_end,
    output dfp_pkg::bundle_t              bundle
);

    localparam logic [dfp_pkg::ACC_W-1:0] TOPIC_LIM = dfp_pkg::ACC_W'(TOPIC_CAPACITY);
    localparam logic [dfp_pkg::ACC_W-1:0] DATA_LIM  = dfp_pkg::ACC_W'(DATA_CAPACITY);
    localparam logic [dfp_pkg::VCNT_W-1:0] VCNT_LAST =
        dfp_pkg::VCNT_W'(dfp_pkg::VARINT_MAX - 1);

    dfp_pkg::phase_t                    phase_reg, phase_next;
    logic [dfp_pkg::TYPE_W-1:0]         type_reg, type_next;
    logic [dfp_pkg::ACC_W-1:0]          acc_reg, acc_next;
    logic                               big_reg, big_next;
    logic [dfp_pkg::VCNT_W-1:0]         vcnt_reg, vcnt_next;
    logic [BL_W-1:0]                    bl_reg, bl_next;
    logic [dfp_pkg::POS_W-1:0]          pos_reg, pos_next;

    logic [6:0]                         bits;
    logic [dfp_pkg::ACC_W-1:0]          acc_or;
    logic                               ovf;
    logic [dfp_pkg::ACC_W-1:0]          acc_new;
    logic                               big_new;
    logic                               cont;
    logic                               overlong;
    logic [BL_W-1:0]                    bl_dec;
    dfp_pkg::bundle_t                   b;
    dfp_pkg::result_t                   item;

    assign bits = data_byte[6:0];
    assign cont = data_byte[7];

    // place of this varint byte within the 17-bit accumulator
    always_comb
    begin
        acc_or = '0;
        ovf    = 1'b0;
        case (vcnt_reg)
            4'd0: acc_or = {10'b0, bits};
            4'd1: acc_or = {3'b0, bits, 7'b0};
            4'd2:
            begin
                acc_or = {bits[2:0], 14'b0};
                ovf    = |bits[6:3];
            end
            default: ovf = |bits;
        endcase
    end

    assign acc_new  = acc_reg | acc_or;
    assign big_new  = big_reg | ovf;
    assign overlong = cont && (vcnt_reg == VCNT_LAST);
    assign bl_dec   = (bl_reg != '0) ? bl_reg - BL_W'(1) : bl_reg;

    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        acc_next   = acc_reg;
        big_next   = big_reg;
        vcnt_next  = vcnt_reg;
        bl_next    = bl_reg;
        pos_next   = pos_reg;
        b          = '0;
        item       = '0;

        case (phase_reg)
            dfp_pkg::PH_TYPE, dfp_pkg::PH_TOPIC_LEN, dfp_pkg::PH_DATA_LEN:
            begin
                acc_next = acc_new;
                big_next = big_new;
                if (overlong)
                begin
                    item.kind = dfp_pkg::KIND_FAIL;
                    item.last = 1'b1;
                    b.r0 = item;
                    b.n = 2'd1;
                    phase_next = dfp_pkg::PH_DONE;
                end
                else if (cont)
                begin
                    vcnt_next = vcnt_reg + dfp_pkg::VCNT_W'(1);
                end
                else if (phase_reg == dfp_pkg::PH_TYPE)
                begin
                    if (big_new || acc_new > dfp_pkg::ACC_W'(dfp_pkg::TYPE_MAX))
                    begin
                        item.kind = dfp_pkg::KIND_FAIL;
                        item.last = 1'b1;
                        b.r0 = item;
                        b.n = 2'd1;
                        phase_next = dfp_pkg::PH_DONE;
                    end
                    else
                    begin
                        type_next  = acc_new[dfp_pkg::TYPE_W-1:0];
                        item.kind  = dfp_pkg::KIND_TYPE;
                        item.value = dfp_pkg::VALUE_W'(acc_new[dfp_pkg::TYPE_W-1:0]);
                        b.r0 = item;
                        b.n = 2'd1;
                        if (acc_new[dfp_pkg::TYPE_W-1:0] == dfp_pkg::TYPE_WELCOME)
                        begin
                            b.r1.kind = dfp_pkg::KIND_OK;
                            b.r1.last = 1'b1;
                            b.n = 2'd2;
                            phase_next = dfp_pkg::PH_DONE;
                        end
                        else if (acc_new[dfp_pkg::TYPE_W-1:0] == dfp_pkg::TYPE_ERROR)
                        begin
                            phase_next = dfp_pkg::PH_REASON;
                        end
                        else
                        begin
                            acc_next   = '0;
                            big_next   = 1'b0;
                            vcnt_next  = '0;
                            phase_next = dfp_pkg::PH_TOPIC_LEN;
                        end
                    end
                end
                else if (phase_reg == dfp_pkg::PH_TOPIC_LEN)
                begin
                    if (big_new || acc_new >= TOPIC_LIM)
                    begin
                        item.kind = dfp_pkg::KIND_FAIL;
                        item.last = 1'b1;
                        b.r0 = item;
                        b.n = 2'd1;
                        phase_next = dfp_pkg::PH_DONE;
                    end
                    else
                    begin
                        bl_next  = acc_new[BL_W-1:0];
                        pos_next = '0;
                        if (acc_new != '0)
                        begin
                            phase_next = dfp_pkg::PH_TOPIC;
                        end
                        else if (type_reg == dfp_pkg::TYPE_MESSAGE)
                        begin
                            acc_next   = '0;
                            big_next   = 1'b0;
                            vcnt_next  = '0;
                            phase_next = dfp_pkg::PH_DATA_LEN;
                        end
                        else
                        begin
                            item.kind = dfp_pkg::KIND_OK;
                            item.last = 1'b1;
                            b.r0 = item;
                            b.n = 2'd1;
                            phase_next = dfp_pkg::PH_DONE;
                        end
                    end
                end
                else
                begin
                    if (big_new || acc_new > DATA_LIM)
                    begin
                        item.kind = dfp_pkg::KIND_FAIL;
                    end
                    else
                    begin
                        bl_next   = acc_new[BL_W-1:0];
                        pos_next  = '0;
                        item.kind = dfp_pkg::KIND_OK;
                    end
                    if (big_new || acc_new > DATA_LIM || acc_new == '0)
                    begin
                        item.last = 1'b1;
                        b.r0 = item;
                        b.n = 2'd1;
                        phase_next = dfp_pkg::PH_DONE;
                    end
                    else
                    begin
                        phase_next = dfp_pkg::PH_DATA;
                    end
                end
            end
            dfp_pkg::PH_REASON:
            begin
                b.r0.kind  = dfp_pkg::KIND_REASON;
                b.r0.value = data_byte;
                b.r1.kind  = dfp_pkg::KIND_OK;
                b.r1.last  = 1'b1;
                b.n = 2'd2;
                phase_next = dfp_pkg::PH_DONE;
            end
            dfp_pkg::PH_TOPIC, dfp_pkg::PH_DATA:
            begin
                b.r0.kind  = (phase_reg == dfp_pkg::PH_TOPIC) ?
                             dfp_pkg::KIND_TOPIC : dfp_pkg::KIND_DATA;
                b.r0.value = data_byte;
                b.r0.index = pos_reg;
                b.n = 2'd1;
                pos_next = pos_reg + dfp_pkg::POS_W'(1);
                bl_next  = bl_dec;
                if (bl_dec == '0)
                begin
                    if (phase_reg == dfp_pkg::PH_TOPIC && type_reg == dfp_pkg::TYPE_MESSAGE)
                    begin
                        acc_next   = '0;
                        big_next   = 1'b0;
                        vcnt_next  = '0;
                        phase_next = dfp_pkg::PH_DATA_LEN;
                    end
                    else
                    begin
                        b.r1.kind  = dfp_pkg::KIND_OK;
                        b.r1.last  = 1'b1;
                        b.n = 2'd2;
                        phase_next = dfp_pkg::PH_DONE;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // frame ends: fail if not complete, then back to the reset state
        if (frame_end)
        begin
            if (phase_next != dfp_pkg::PH_DONE)
            begin
                if (b.n == 2'd0)
                begin
                    b.r0.kind = dfp_pkg::KIND_FAIL;
                    b.r0.last = 1'b1;
                    b.n = 2'd1;
                end
                else
                begin
                    b.r1.kind = dfp_pkg::KIND_FAIL;
                    b.r1.last = 1'b1;
                    b.n = 2'd2;
                end
            end
            phase_next = dfp_pkg::PH_TYPE;
            type_next  = '0;
            acc_next   = '0;
            big_next   = 1'b0;
            vcnt_next  = '0;
            bl_next    = '0;
            pos_next   = '0;
        end
    end

    assign bundle = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dfp_pkg::PH_TYPE;
            type_reg  <= '0;
            acc_reg   <= '0;
            big_reg   <= 1'b0;
            vcnt_reg  <= '0;
            bl_reg    <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            acc_reg   <= acc_next;
            big_reg   <= big_next;
            vcnt_reg  <= vcnt_next;
            bl_reg    <= bl_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

@@ hw/rtl/dfp_result_fifo.sv @@
// Four-entry result queue: takes up to two results a cycle, gives one while out_ready is high.
module dfp_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dfp_pkg::bundle_t  bundle,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output dfp_pkg::result_t  out_item
);

    dfp_pkg::result_t  mem_reg [4];
    logic [1:0]        wr_reg, wr_next;
    logic [1:0]        rd_reg, rd_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [1:0]        n_push;
    logic              pop;

    assign n_push    = push ? bundle.n : 2'd0;
    assign out_valid = (cnt_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_reg];
    // room for a worst-case pair, independent of the downstream ready
    assign space     = (cnt_reg <= 3'd2);

    assign wr_next  = wr_reg + n_push;
    assign rd_next  = rd_reg + {1'b0, pop};
    assign cnt_next = cnt_reg + {1'b0, n_push} - {2'b0, pop};

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            mem_reg[wr_reg] <= bundle.r0;
        end
        if (n_push == 2'd2)
        begin
            mem_reg[wr_reg + 2'd1] <= bundle.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/downlink_frame_parser_top.sv @@
// Downlink frame parser top level: stream ports, parser and result queue.
//
// Takes one frame byte per cycle while s_tready is high and decodes it in the
// same cycle; its one or two results enter a four-entry result queue and leave
// one per cycle while m_tready is high, each registered in the queue before it
// is offered. A byte that causes two results (type plus success, reason plus
// success, last field byte plus success, or a result plus an early-end failure)
// holds the output longer than a byte with one; the sustained byte rate is set
// by the output port at one result per cycle. s_tready is high whenever the
// queue holds two results or fewer.
module downlink_frame_parser_top #(
    parameter int TOPIC_CAPACITY = 64,
    parameter int DATA_CAPACITY  = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tlast,    // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // out_value [7:0], out_index [15:8]
    output logic [2:0]  m_tuser,    // out_kind
    output logic        m_tlast     // last
);

    localparam int LEN_MAX = (TOPIC_CAPACITY - 1 > DATA_CAPACITY) ?
                             TOPIC_CAPACITY - 1 : DATA_CAPACITY;
    localparam int BL_W    = $clog2(LEN_MAX + 1);

    logic              accept;
    dfp_pkg::bundle_t  bundle;
    dfp_pkg::result_t  item;

    assign accept = s_tvalid && s_tready;

    dfp_parser #(
        .TOPIC_CAPACITY (TOPIC_CAPACITY),
        .DATA_CAPACITY  (DATA_CAPACITY),
        .BL_W           (BL_W)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata),
        .frame_end (s_tlast),
        .bundle    (bundle)
    );

    dfp_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .bundle    (bundle),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (item)
    );

    assign m_tdata = {item.index, item.value};
    assign m_tuser = item.kind;
    assign m_tlast = item.last;

`ifndef SYNTH
    // only status results close a frame result
    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |->
            (m_tuser == dfp_pkg::KIND_OK) || (m_tuser == dfp_pkg::KIND_FAIL))
        else $error("tlast on a non-status result");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == dfp_pkg::KIND_OK) || (m_tuser == dfp_pkg::KIND_FAIL))
            |-> m_tlast && (m_tdata == 16'd0))
        else $error("status result without tlast or with payload");

    a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == dfp_pkg::KIND_TYPE) |->
            (m_tdata[7:0] <= 8'd4) && (m_tdata[15:8] == 8'd0))
        else $error("type result out of range");
`endif

endmodule
